FILE: rtl/core/rup_pkg.sv
package rup_pkg;

    localparam int unsigned ACC_DEPTH_DEFAULT = 4096;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABILITY_OFFSET = 2'd1;

    localparam logic [23:0] RESET_LEARNING_RATE    = 24'd167772;
    localparam logic [31:0] RESET_STABILITY_OFFSET = 32'd430;

    // step counts of the sequencer phases
    localparam logic [5:0] STEPS_MOD   = 6'd2;
    localparam logic [5:0] STEPS_DIV10 = 6'd7;
    localparam logic [5:0] STEPS_SQRT  = 6'd25;
    localparam logic [5:0] STEPS_DIV   = 6'd24;

    localparam logic [23:0] LIMIT_POS = 24'd8388607;
    localparam logic [23:0] LIMIT_NEG = 24'd8388608;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MOD,
        S_RDA,
        S_MULG,
        S_SUM,
        S_DIV10,
        S_WB,
        S_SQRT,
        S_MULE,
        S_DPREP,
        S_DCHK,
        S_DIV,
        S_FIN
    } t_state;

endpackage

FILE: rtl/core/rmsprop_update.sv
// rmsprop optimiser step, one weight element per beat. an input beat carries an element
// address and a signed q8.16 gradient g. the block updates the element's running mean
// square acc = 0.9*acc + 0.1*g^2 (q16.32, round to nearest) in an on-chip memory and
// returns delta = -eta*g/sqrt(acc+epsilon) in signed q8.16, saturated, with tuser set
// when saturation happened. addresses are taken modulo ACC_DEPTH. after reset the block
// sweeps the memory to zero, one entry a cycle, before it takes the first beat;
// configuration writes are taken at any time but meant only while idle. a beat is
// taken only in the idle state, after the previous beat has gone through the address
// reduction (reciprocal multiply), the memory read, g^2 on the shared 24x24 multiplier,
// the sum, the shift-and-add division by ten, the write-back, 25 square root steps on
// the shared compare-subtract unit, the multiply by eta, the divider set-up, the overflow
// check, 24 divider steps and the final step. zero gradient or zero rate ends after the
// write-back, a quotient overflow skips the divider steps and a zero root skips the
// check as well. the result waits in an output register, so the next beat is accepted
// while it is still pending; the final step stalls only while an earlier result is
// still unread.
module rmsprop_update #(
    parameter int unsigned ACC_DEPTH = rup_pkg::ACC_DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rup_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // input beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // element_address[11:0], grad_value[35:12], zero pad
    // result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // weight_delta[23:0]
    output logic                          m_axis_tuser   // clipped[0]
);
    import rup_pkg::*;

    localparam int unsigned AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    // reciprocal of the depth, exact for any 12 bit address
    localparam int unsigned MOD_K = 12 + $clog2(ACC_DEPTH);
    localparam longint unsigned MOD_M =
        ((64'd1 << MOD_K) + 64'(ACC_DEPTH) - 64'd1) / 64'(ACC_DEPTH);

    t_state r_state, n_state;

    // configuration registers
    logic [23:0] r_eta;
    logic [31:0] r_eps;

    // sequencer and datapath registers
    logic [5:0]    r_cnt;
    logic [AW-1:0] r_addr;
    logic [23:0]   r_mag;
    logic          r_neg;
    logic          r_zero;
    logic          r_clip;
    logic [47:0]   r_rdata;
    logic [47:0]   r_prod;
    logic [49:0]   r_work;
    logic [49:0]   r_quo;
    logic [33:0]   r_rem;
    logic [24:0]   r_root;
    logic [33:0]   r_den;

    // output register
    logic          r_ovalid;
    logic [23:0]   r_odata;
    logic          r_ouser;

    // accumulator memory
    logic [47:0] r_mem [ACC_DEPTH];
    logic        mem_we;
    logic [47:0] mem_wdata;

    // shared compare-subtract unit
    logic [51:0] sh_a, sh_b;
    logic [52:0] sh_diff;
    logic        sh_ge;

    // shared multiplier
    logic [23:0] mul_b;

    logic        in_beat, out_beat, out_free;
    logic [23:0] grad;
    logic [48:0] div_num;
    logic [23:0] limit;
    logic [23:0] res_mag;
    logic        res_clip;
    logic        cnt_done;
    logic [45:0] mod_prod;
    logic [31:0] mod_rem;
    logic [49:0] div10_q;
    logic [49:0] div10_back;

    assign in_beat  = s_axis_tvalid & s_axis_tready;
    assign out_beat = r_ovalid & m_axis_tready;
    assign out_free = ~r_ovalid | m_axis_tready;
    assign grad     = s_axis_tdata[35:12];
    assign cnt_done = (r_cnt == 6'd0);

    // address reduction: quotient by reciprocal, then remainder
    assign mod_prod = 46'(r_work[49:38]) * 46'(MOD_M);
    assign mod_rem  = 32'(r_work[49:38]) - 32'(r_quo[11:0]) * 32'(ACC_DEPTH);

    // division by ten: estimate is at most one short, remainder below twenty
    assign div10_q    = r_quo >> 3;
    assign div10_back = r_work - ((div10_q << 3) + (div10_q << 1));

    // ---------------------------------------------------------------- shared unit
    always_comb begin
        case (r_state)
            S_DIV10: begin
                sh_a = 52'(r_rem);
                sh_b = 52'd10;
            end
            S_SQRT: begin
                sh_a = 52'({r_rem, r_work[49:48]});
                sh_b = 52'({r_root, 2'b01});
            end
            S_DCHK: begin
                sh_a = 52'(r_rem);
                sh_b = 52'(r_den);
            end
            S_DIV: begin
                sh_a = 52'({r_rem, r_work[49]});
                sh_b = 52'(r_den);
            end
            default: begin
                sh_a = '0;
                sh_b = '0;
            end
        endcase
        sh_diff = {1'b0, sh_a} - {1'b0, sh_b};
        sh_ge   = ~sh_diff[52];
    end

    assign mul_b   = (r_state == S_MULG) ? r_mag : r_eta;
    // numerator with half the divisor added for round to nearest
    assign div_num = 49'(r_prod) + 49'({r_root, 7'b0});

    // final saturation
    always_comb begin
        limit    = r_neg ? LIMIT_POS : LIMIT_NEG;
        res_clip = r_clip | (r_work[23:0] > limit);
        if (r_zero) begin
            res_mag  = '0;
            res_clip = 1'b0;
        end else if (res_clip) begin
            res_mag = limit;
        end else begin
            res_mag = r_work[23:0];
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:   if (r_addr == AW'(ACC_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_beat) n_state = S_MOD;
            S_MOD:   if (cnt_done) n_state = S_RDA;
            S_RDA:   n_state = S_MULG;
            S_MULG:  n_state = S_SUM;
            S_SUM:   n_state = S_DIV10;
            S_DIV10: if (cnt_done) n_state = S_WB;
            S_WB:    n_state = ((r_mag == '0) || (r_eta == '0)) ? S_FIN : S_SQRT;
            S_SQRT:  if (cnt_done) n_state = S_MULE;
            S_MULE:  n_state = S_DPREP;
            S_DPREP: n_state = (r_root == '0) ? S_FIN : S_DCHK;
            S_DCHK:  n_state = sh_ge ? S_FIN : S_DIV;
            S_DIV:   if (cnt_done) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = r_work[47:0];
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_IDLE:  s_axis_tready = 1'b1;
            S_WB:    mem_we = 1'b1;
            default: ;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // ---------------------------------------------------------------- memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_eta    <= RESET_LEARNING_RATE;
            r_eps    <= RESET_STABILITY_OFFSET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEARNING_RATE:    r_eta <= i_cfg_data[23:0];
                    CFG_STABILITY_OFFSET: r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_beat) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= cnt_done ? 6'd0 : r_cnt - 6'd1;
            case (r_state)
                S_CLR: r_addr <= r_addr + AW'(1);
                S_IDLE: begin
                    if (in_beat) begin
                        r_work <= {s_axis_tdata[11:0], 38'b0};
                        r_rem  <= '0;
                        r_neg  <= grad[23];
                        r_mag  <= grad[23] ? 24'(24'd0 - grad) : grad;
                        r_zero <= 1'b0;
                        r_clip <= 1'b0;
                        r_cnt  <= STEPS_MOD - 6'd1;
                    end
                end
                S_MOD: begin
                    // address modulo depth, quotient first then remainder
                    if (cnt_done) begin
                        r_addr <= mod_rem[AW-1:0];
                    end else begin
                        r_quo <= 50'(mod_prod >> MOD_K);
                    end
                end
                S_MULG: r_prod <= r_mag * mul_b;
                S_SUM: begin
                    r_work <= 50'({r_rdata, 3'b0}) + 50'(r_rdata) + 50'(r_prod) + 50'd5;
                    r_rem  <= '0;
                    r_cnt  <= STEPS_DIV10 - 6'd1;
                end
                S_DIV10: begin
                    // x*0.8 by shift and add, then divide by eight and fix up
                    case (r_cnt)
                        6'd6: r_quo <= (r_work >> 1) + (r_work >> 2);
                        6'd5: r_quo <= r_quo + (r_quo >> 4);
                        6'd4: r_quo <= r_quo + (r_quo >> 8);
                        6'd3: r_quo <= r_quo + (r_quo >> 16);
                        6'd2: r_quo <= r_quo + (r_quo >> 32);
                        6'd1: begin
                            r_quo <= div10_q;
                            r_rem <= div10_back[33:0];
                        end
                        default: r_work <= r_quo + 50'(sh_ge);
                    endcase
                end
                S_WB: begin
                    // work holds the new mean square, written back this cycle
                    r_work <= 50'(r_work[47:0]) + 50'(r_eps);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_zero <= (r_mag == '0) || (r_eta == '0);
                    r_cnt  <= STEPS_SQRT - 6'd1;
                end
                S_SQRT: begin
                    r_rem  <= sh_ge ? sh_diff[33:0] : sh_a[33:0];
                    r_root <= {r_root[23:0], sh_ge};
                    r_work <= {r_work[47:0], 2'b00};
                end
                S_MULE: r_prod <= r_mag * mul_b;
                S_DPREP: begin
                    r_den  <= 34'({r_root, 8'b0});
                    r_rem  <= 34'(div_num[48:24]);
                    r_work <= {div_num[23:0], 26'b0};
                    r_clip <= (r_root == '0);
                end
                S_DCHK: begin
                    r_clip <= sh_ge;
                    r_cnt  <= STEPS_DIV - 6'd1;
                end
                S_DIV: begin
                    r_rem  <= sh_ge ? sh_diff[33:0] : sh_a[33:0];
                    r_work <= {r_work[48:0], sh_ge};
                end
                S_FIN: begin
                    if (out_free) begin
                        r_odata <= r_neg ? res_mag : 24'(24'd0 - res_mag);
                        r_ouser <= res_clip;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- assertions
    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !s_axis_tready)
        else $error("input beat offered during memory clear");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_FIN))
        else $error("result raised outside final step");

    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata == 24'h7FFFFF || m_axis_tdata == 24'h800000)
        else $error("clipped result not at full scale");

    a_counter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < STEPS_SQRT)
        else $error("step counter out of range");

endmodule

FILE: bench/rmsprop_update_tb.sv
`timescale 1ns / 100ps

module rmsprop_update_tb;
    import rup_pkg::*;

    localparam int unsigned DEPTH = 4096;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [23:0] delta;
        logic        clip;
    } t_step_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata;  // element_address[11:0], grad_value[35:12], zero pad
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata;  // weight_delta[23:0]
    logic m_axis_tuser;         // clipped[0]

    // predictor state
    logic [47:0] mean_sq[DEPTH];
    logic [23:0] eta_now;
    logic [31:0] eps_now;
    t_step_out   pending_steps[$];

    int unsigned error_count;
    bit          no_idle;
    int unsigned hold_token;
    int unsigned hold_seen;
    int unsigned hold_left;

    rmsprop_update i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // integer square root, truncated
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // one optimiser step: updates the mean square entry and returns the delta
    function automatic t_step_out rmsprop_step(input logic [11:0] addr,
                                               input logic [23:0] grad);
        t_step_out   o;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] acc;
        logic [63:0] root;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] lim;
        logic [63:0] rmag;
        neg  = grad[23];
        mag  = neg ? (64'h100_0000 - {40'd0, grad}) : {40'd0, grad};
        acc  = {16'd0, mean_sq[addr % DEPTH]};
        acc  = ((64'd9 * acc + mag * mag + 64'd5) / 64'd10) & 64'hFFFF_FFFF_FFFF;
        mean_sq[addr % DEPTH] = acc[47:0];
        o = '0;
        if (mag == 0 || eta_now == 0) return o;
        root = int_sqrt(acc + {32'd0, eps_now});
        lim  = neg ? {40'd0, LIMIT_POS} : {40'd0, LIMIT_NEG};
        if (root == 0) begin
            // divider overflow: full scale, opposite in sign to g
            rmag   = lim;
            o.clip = 1'b1;
        end else begin
            den = root << 8;
            q   = ({40'd0, eta_now} * mag + (den >> 1)) / den;
            if (q > lim) begin
                rmag   = lim;
                o.clip = 1'b1;
            end else begin
                rmag = q;
            end
        end
        o.delta = neg ? rmag[23:0] : 24'(64'h100_0000 - rmag);
        return o;
    endfunction

    // result side: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 26);
        end
    end

    // compare every result beat with the oldest expected step
    always @(posedge i_clk) begin
        t_step_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_steps.size() == 0) begin
                $display("%0t: result beat with nothing expected, got delta %h clip %b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_steps.pop_front();
                if (m_axis_tdata !== want.delta) begin
                    $display("%0t: weight_delta expected %h actual %h",
                             $time, want.delta, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.clip) begin
                    $display("%0t: clipped expected %b actual %b",
                             $time, want.clip, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic send_grad(input logic [11:0] addr, input logic [23:0] grad);
        if (!no_idle && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, grad, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_steps.push_back(rmsprop_step(addr, grad));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LEARNING_RATE) eta_now = val[23:0];
        else if (idx == CFG_STABILITY_OFFSET) eps_now = val;
    endtask

    function automatic logic [23:0] rand_grad;
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 512)) - 256);
            2: return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
            3: return 24'($signed($urandom_range(0, 131072)) - 65536);
            4: return $urandom_range(1) ? 24'($urandom_range(1, 2)) : -24'($urandom_range(1, 2));
            default: return 24'($urandom) >> $urandom_range(0, 20);
        endcase
    endfunction

    function automatic logic [11:0] rand_addr;
        // mostly a small set, so that mean squares build up
        if ($urandom_range(3) != 0) return 12'($urandom_range(0, 31));
        return 12'($urandom);
    endfunction

    task automatic test_directed;
        send_grad(12'd0, 24'h7F_FFFF);
        send_grad(12'd0, 24'h80_0000);
        send_grad(12'd4095, 24'h00_0001);
        send_grad(12'd4095, 24'hFF_FFFF);
        send_grad(12'd1, 24'h00_0000);
        send_grad(12'd2, 24'h01_0000);
        send_grad(12'd2, 24'h01_0000);
        send_grad(12'hAAA, 24'h55_5555);
        send_grad(12'h555, 24'hAA_AAAA);
        // zero rate gives a zero step
        write_reg(CFG_LEARNING_RATE, 32'd0);
        send_grad(12'd3, 24'h12_3456);
        send_grad(12'd3, 24'hED_CBA9);
        // zero root: epsilon zero and fresh entries with tiny gradients, then one full-scale gradient
        write_reg(CFG_LEARNING_RATE, 32'h00FF_FFFF);
        write_reg(CFG_STABILITY_OFFSET, 32'd0);
        send_grad(12'd100, 24'h00_0001);
        send_grad(12'd101, 24'hFF_FFFE);
        send_grad(12'd102, 24'h00_0002);
        send_grad(12'd103, 24'hFF_FFFF);
        send_grad(12'd104, 24'h7F_FFFF);
        // unknown index is ignored
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_SPARE, 32'h1234_5678);
        send_grad(12'd105, 24'h00_0003);
        write_reg(CFG_STABILITY_OFFSET, 32'hFFFF_FFFF);
        send_grad(12'd0, 24'h80_0000);
        send_grad(12'd106, 24'h00_0001);
        drain();
    endtask

    task automatic test_random_phase(input logic [31:0] eta, input logic [31:0] eps,
                                     input int unsigned n_items);
        write_reg(CFG_LEARNING_RATE, eta);
        write_reg(CFG_STABILITY_OFFSET, eps);
        repeat (n_items) send_grad(rand_addr(), rand_grad());
    endtask

    task automatic test_random;
        test_random_phase({8'd0, RESET_LEARNING_RATE}, RESET_STABILITY_OFFSET, 300);
        test_random_phase(32'h00FF_FFFF, 32'hFFFF_FFFF, 250);
        test_random_phase(32'd1, 32'd0, 250);
        // stretch without idling on either side
        no_idle = 1'b1;
        test_random_phase(32'($urandom), 32'($urandom_range(0, 4096)), 250);
        no_idle = 1'b0;
        test_random_phase(32'($urandom), $urandom, 250);
        // sender pauses until every result is back, then carries on
        drain();
        test_random_phase(32'h00FF_FFFF, 32'd0, 250);
        test_random_phase(32'($urandom), 32'($urandom_range(0, 255)), 250);
    endtask

    task automatic test_backpressure;
        // receiver holds off while the sender keeps offering
        hold_token++;
        repeat (12) send_grad(rand_addr(), rand_grad());
        drain();
    endtask

    initial begin
        error_count   = 0;
        no_idle       = 1'b0;
        hold_token    = 0;
        hold_seen     = 0;
        hold_left     = 0;
        eta_now       = RESET_LEARNING_RATE;
        eps_now       = RESET_STABILITY_OFFSET;
        for (int i = 0; i < DEPTH; i++) mean_sq[i] = '0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();
        test_backpressure();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_steps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/rup_pkg.sv
rtl/core/rmsprop_update.sv
bench/rmsprop_update_tb.sv
